### rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg: shared types and constants of the controller reply deframer
// Result codes, end code classes, error codes and the list of protocol
// error end codes used by the classifier.
// ----------------------------------------------------------------------------
package prd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLASS_SUCCESS  = 2'd0,
    CLASS_DEVICE   = 2'd1,
    CLASS_PROTOCOL = 2'd2,
    CLASS_UNKNOWN  = 2'd3
  } end_class_e;

  typedef enum logic [1:0] {
    ERR_SUBHEADER = 2'd0,
    ERR_SERIAL    = 2'd1,
    ERR_LENGTH    = 2'd2
  } error_code_e;

  typedef enum logic {
    REG_FRAME_IS_4E     = 1'b0,
    REG_EXPECTED_SERIAL = 1'b1
  } reg_index_e;

  localparam logic [7:0] SUBHEADER_B0 = 8'hD0;
  localparam logic [7:0] SUBHEADER_B1 = 8'h00;
  localparam logic [3:0] HDR_LEN_3E   = 4'd9;
  localparam logic [3:0] HDR_LEN_4E   = 4'd11;
  localparam logic [15:0] MIN_LENGTH  = 16'd2;

  localparam logic [15:0] CODE_SUCCESS  = 16'h0000;
  localparam logic [15:0] CODE_DEV_B5   = 16'hC0B5;
  localparam logic [15:0] CODE_DEV_200  = 16'hC200;
  localparam logic [15:0] CODE_DEV_201  = 16'hC201;

  localparam int unsigned NumProtoCodes = 13;
  localparam logic [15:0] PROTO_CODES [NumProtoCodes] = '{
    16'h0005, 16'h0006, 16'hC050, 16'hC051, 16'hC052, 16'hC056, 16'hC058,
    16'hC059, 16'hC05B, 16'hC05C, 16'hC05F, 16'hC060, 16'hC061
  };

  typedef struct packed {
    logic        frame_is_4e;
    logic [15:0] expected_serial;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] reply_code;
    error_code_e error_code;
    logic        last;
  } step_t;

endpackage

### rtl/prd_classify.sv
// ----------------------------------------------------------------------------
// prd_classify: end code classifier
// Sorts a registered end code into success, device-level, known protocol
// error or unknown.
// ----------------------------------------------------------------------------
module prd_classify (
  input  logic [15:0]               reply_code_i,
  output prd_pkg::end_class_e       end_class_o
);

  logic proto_hit;

  always_comb begin
    proto_hit = 1'b0;
    for (int i = 0; i < prd_pkg::NumProtoCodes; i++) begin
      if (reply_code_i == prd_pkg::PROTO_CODES[i]) begin
        proto_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (reply_code_i == prd_pkg::CODE_SUCCESS) begin
      end_class_o = prd_pkg::CLASS_SUCCESS;
    end else if (reply_code_i == prd_pkg::CODE_DEV_B5 ||
                 reply_code_i == prd_pkg::CODE_DEV_200 ||
                 reply_code_i == prd_pkg::CODE_DEV_201) begin
      end_class_o = prd_pkg::CLASS_DEVICE;
    end else if (proto_hit) begin
      end_class_o = prd_pkg::CLASS_PROTOCOL;
    end else begin
      end_class_o = prd_pkg::CLASS_UNKNOWN;
    end
  end

endmodule

### rtl/prd_parser.sv
// ----------------------------------------------------------------------------
// prd_parser: reply header walker
// Holds the header position and length state and works out, for each
// accepted byte, the result it causes and the next state.
// ----------------------------------------------------------------------------
module prd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  prd_pkg::cfg_t   cfg_i,
  output prd_pkg::step_t  step_o
);

  logic [3:0]  pos_q, pos_d;
  logic        in_payload_q, in_payload_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] length_q, length_d;
  logic [15:0] remain_q, remain_d;
  logic [3:0]  hdr;
  logic [15:0] word;

  assign hdr  = cfg_i.frame_is_4e ? prd_pkg::HDR_LEN_4E : prd_pkg::HDR_LEN_3E;
  assign word = {rx_byte_i, low_q};

  always_comb begin
    pos_d        = pos_q;
    in_payload_d = in_payload_q;
    low_d        = low_q;
    length_d     = length_q;
    remain_d     = remain_q;
    step_o       = '0;
    step_o.kind       = prd_pkg::KIND_DATA;
    step_o.error_code = prd_pkg::ERR_SUBHEADER;

    if (in_payload_q) begin
      step_o.valid     = 1'b1;
      step_o.data_byte = rx_byte_i;
      remain_d         = remain_q - 16'd1;
      if (remain_d == '0) begin
        step_o.last  = 1'b1;
        pos_d        = '0;
        in_payload_d = 1'b0;
      end
    end else if (pos_q == 4'd0 || pos_q == 4'd1) begin
      if (rx_byte_i != ((pos_q == 4'd0) ? prd_pkg::SUBHEADER_B0 : prd_pkg::SUBHEADER_B1)) begin
        step_o.valid      = 1'b1;
        step_o.kind       = prd_pkg::KIND_ERROR;
        step_o.error_code = prd_pkg::ERR_SUBHEADER;
        step_o.last       = 1'b1;
        pos_d             = '0;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end else if (pos_q > hdr + 4'd1) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + 4'd1;
      if (cfg_i.frame_is_4e && pos_q == 4'd2) begin
        low_d = rx_byte_i;
      end else if (cfg_i.frame_is_4e && pos_q == 4'd3) begin
        if (word != cfg_i.expected_serial) begin
          step_o.valid      = 1'b1;
          step_o.kind       = prd_pkg::KIND_ERROR;
          step_o.error_code = prd_pkg::ERR_SERIAL;
          step_o.last       = 1'b1;
          pos_d             = '0;
        end
      end else if (pos_q == hdr - 4'd2 || pos_q == hdr) begin
        low_d = rx_byte_i;
      end else if (pos_q == hdr - 4'd1) begin
        length_d = word;
        if (word < prd_pkg::MIN_LENGTH) begin
          step_o.valid      = 1'b1;
          step_o.kind       = prd_pkg::KIND_ERROR;
          step_o.error_code = prd_pkg::ERR_LENGTH;
          step_o.last       = 1'b1;
          pos_d             = '0;
        end
      end else if (pos_q == hdr + 4'd1) begin
        step_o.valid      = 1'b1;
        step_o.kind       = prd_pkg::KIND_END;
        step_o.reply_code = word;
        remain_d          = length_q - prd_pkg::MIN_LENGTH;
        pos_d             = '0;
        if (remain_d == '0) begin
          step_o.last = 1'b1;
        end else begin
          in_payload_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_payload_q <= 1'b0;
      low_q        <= '0;
      length_q     <= '0;
      remain_q     <= '0;
    end else if (accept_i) begin
      pos_q        <= pos_d;
      in_payload_q <= in_payload_d;
      low_q        <= low_d;
      length_q     <= length_d;
      remain_q     <= remain_d;
    end
  end

endmodule

### rtl/plc_reply_deframer.sv
// ----------------------------------------------------------------------------
// plc_reply_deframer: binary 3E/4E controller reply deframer
// Walks reply headers byte by byte and delivers end codes, data bytes and
// header errors.
// ----------------------------------------------------------------------------
// Reply bytes enter on the rx_byte channel (in_valid_i / in_ready_o), one
// transfer per byte. Results leave on the output channel (out_valid_o /
// out_ready_i) with kind, data_byte, reply_code, end_class, error_code and last.
// A byte that causes a result shows it in the cycle after its transfer, from the
// result register; header bytes that cause no result are consumed silently.
// Throughput is one byte per cycle while no result is stalled: the header state
// update and the result decode are combinational between the accepted byte and
// the result register. While the result register holds a result that the
// receiver has not taken, in_ready_o is low; it rises in the same cycle that
// out_ready_i takes the result, so a steady receiver sees no bubbles.
// Reset clears the header position, the payload state and the result register;
// the block then expects the first subheader byte. frame_is_4e (index 0) and
// expected_serial (index 1) reset to zero. The user must write them through
// cfg_we_i only while no reply is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module plc_reply_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] reply_code_o,
  output logic [1:0]  end_class_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);

  prd_pkg::cfg_t       cfg_q;
  prd_pkg::step_t      step;
  prd_pkg::step_t      res_q;
  logic                out_valid_q;
  logic                accept;
  prd_pkg::end_class_e end_class;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (prd_pkg::reg_index_e'(cfg_index_i))
        prd_pkg::REG_FRAME_IS_4E:     cfg_q.frame_is_4e     <= cfg_wdata_i[0];
        prd_pkg::REG_EXPECTED_SERIAL: cfg_q.expected_serial <= cfg_wdata_i;
        default:                      cfg_q                 <= cfg_q;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  prd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .step_o    (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && step.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept && step.valid) begin
      res_q <= step;
    end
  end

  prd_classify u_classify (
    .reply_code_i (res_q.reply_code),
    .end_class_o  (end_class)
  );

  assign out_valid_o  = out_valid_q;
  assign kind_o       = res_q.kind;
  assign data_byte_o  = res_q.data_byte;
  assign reply_code_o = res_q.reply_code;
  assign end_class_o  = (res_q.kind == prd_pkg::KIND_END) ? end_class : prd_pkg::CLASS_SUCCESS;
  assign error_code_o = res_q.error_code;
  assign last_o       = res_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && out_valid_q && !out_ready_i))
    else $error("Byte transfer taken while a result was stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == prd_pkg::KIND_ERROR |-> res_q.last)
    else $error("Header error result without last.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.kind != 2'd3)
    else $error("Result kind out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != prd_pkg::KIND_DATA |-> res_q.data_byte == '0)
    else $error("Data byte set on a non-data result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && step.valid |=> out_valid_q)
    else $error("Result lost after a byte transfer.");

endmodule

### bench/plc_reply_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_reply_deframer_tb: self-checking bench for the controller reply deframer
// Streams 3E and 4E reply bytes with random gaps on both channels, and
// predicts every end code, data byte and header error in a scoreboard that
// checks each result transfer in order.
// ----------------------------------------------------------------------------

typedef struct {
  prd_pkg::kind_e       kind;
  logic [7:0]           data;
  logic [15:0]          code;
  prd_pkg::end_class_e  cls;
  prd_pkg::error_code_e err;
  logic                 last;
} reply_result_t;

class reply_scoreboard;
  bit            is_4e;
  logic [15:0]   serial;
  logic [3:0]    pos;
  bit            in_data;
  logic [7:0]    low_hold;
  logic [15:0]   length_field;
  logic [15:0]   remaining;
  reply_result_t expected_q[$];
  int unsigned   fails;
  int unsigned   checked;

  function new();
    is_4e        = 1'b0;
    serial       = '0;
    pos          = '0;
    in_data      = 1'b0;
    low_hold     = '0;
    length_field = '0;
    remaining    = '0;
    fails        = 0;
    checked      = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function bit busy();
    return in_data || pos != 4'd0;
  endfunction

  function prd_pkg::end_class_e classify(logic [15:0] c);
    case (c)
      16'h0000: return prd_pkg::CLASS_SUCCESS;
      16'hC0B5, 16'hC200, 16'hC201: return prd_pkg::CLASS_DEVICE;
      16'h0005, 16'h0006, 16'hC050, 16'hC051, 16'hC052, 16'hC056, 16'hC058,
      16'hC059, 16'hC05B, 16'hC05C, 16'hC05F, 16'hC060, 16'hC061:
        return prd_pkg::CLASS_PROTOCOL;
      default: return prd_pkg::CLASS_UNKNOWN;
    endcase
  endfunction

  function void note_config(prd_pkg::reg_index_e idx, logic [15:0] value);
    if (idx == prd_pkg::REG_FRAME_IS_4E) is_4e = value[0];
    else serial = value;
  endfunction

  function void note_byte(logic [7:0] b);
    reply_result_t        r;
    logic [3:0]           hdr;
    logic [15:0]          word;
    bit                   hit;
    bit                   bad;
    bit                   step;
    prd_pkg::error_code_e why;
    r.kind = prd_pkg::KIND_DATA;
    r.data = '0;
    r.code = '0;
    r.cls  = prd_pkg::CLASS_SUCCESS;
    r.err  = prd_pkg::ERR_SUBHEADER;
    r.last = 1'b0;
    hdr    = is_4e ? 4'd11 : 4'd9;
    word   = {b, low_hold};
    hit    = 1'b0;
    bad    = 1'b0;
    step   = 1'b1;
    why    = prd_pkg::ERR_SUBHEADER;
    if (in_data) begin
      hit       = 1'b1;
      step      = 1'b0;
      r.data    = b;
      remaining = remaining - 16'd1;
      if (remaining == 16'd0) begin
        r.last  = 1'b1;
        in_data = 1'b0;
      end
    end else if (pos == 4'd0) bad = (b != prd_pkg::SUBHEADER_B0);
    else if (pos == 4'd1) bad = (b != prd_pkg::SUBHEADER_B1);
    else if (pos > hdr + 4'd1) begin
      pos  = 4'd0;
      step = 1'b0;
    end else if (is_4e && pos == 4'd2) low_hold = b;
    else if (is_4e && pos == 4'd3) begin
      bad = (word != serial);
      why = prd_pkg::ERR_SERIAL;
    end else if (pos == hdr - 4'd2 || pos == hdr) low_hold = b;
    else if (pos == hdr - 4'd1) begin
      length_field = word;
      bad          = (word < 16'd2);
      why          = prd_pkg::ERR_LENGTH;
    end else if (pos == hdr + 4'd1) begin
      hit       = 1'b1;
      step      = 1'b0;
      r.kind    = prd_pkg::KIND_END;
      r.code    = word;
      r.cls     = classify(word);
      remaining = length_field - 16'd2;
      pos       = 4'd0;
      if (remaining == 16'd0) r.last = 1'b1;
      else in_data = 1'b1;
    end
    if (bad) begin
      hit     = 1'b1;
      r.kind  = prd_pkg::KIND_ERROR;
      r.err   = why;
      r.last  = 1'b1;
      pos     = 4'd0;
      in_data = 1'b0;
    end else if (step) begin
      pos = pos + 4'd1;
    end
    if (hit) expected_q.push_back(r);
  endfunction

  task report(string msg);
    if (fails < 100) $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  task check_result(logic [1:0] k, logic [7:0] d, logic [15:0] c, logic [1:0] cl,
                    logic [1:0] e, logic l);
    reply_result_t w;
    checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with none expected, kind %0d", checked, k));
      return;
    end
    w = expected_q.pop_front();
    if (k !== w.kind)
      report($sformatf("result %0d kind %0d, want %0d", checked, k, w.kind));
    if (d !== w.data)
      report($sformatf("result %0d data_byte %h, want %h", checked, d, w.data));
    if (c !== w.code)
      report($sformatf("result %0d reply_code %h, want %h", checked, c, w.code));
    if (cl !== w.cls)
      report($sformatf("result %0d end_class %0d, want %0d", checked, cl, w.cls));
    if (e !== w.err)
      report($sformatf("result %0d error_code %0d, want %0d", checked, e, w.err));
    if (l !== w.last)
      report($sformatf("result %0d last %0d, want %0d", checked, l, w.last));
  endtask
endclass

module plc_reply_deframer_tb;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] reply_code_o;
  logic [1:0]  end_class_o;
  logic [1:0]  error_code_o;
  logic        last_o;

  reply_scoreboard sb = new();
  bit              quiet = 1'b0;
  bit              cur_4e = 1'b0;
  logic [15:0]     cur_serial = '0;
  int unsigned     items_sent = 0;

  plc_reply_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .reply_code_o(reply_code_o),
    .end_class_o (end_class_o),
    .error_code_o(error_code_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < 37);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] mode, input logic [15:0] ser);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= prd_pkg::REG_FRAME_IS_4E;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    sb.note_config(prd_pkg::REG_FRAME_IS_4E, mode);
    cfg_index_i <= prd_pkg::REG_EXPECTED_SERIAL;
    cfg_wdata_i <= ser;
    @(posedge clk_i);
    sb.note_config(prd_pkg::REG_EXPECTED_SERIAL, ser);
    cfg_we_i   <= 1'b0;
    cur_4e     = mode[0];
    cur_serial = ser;
  endtask

  // Zero bytes push any half-walked header into an error or a short reply.
  task automatic flush_to_start();
    while (sb.busy()) send_byte(8'h00);
  endtask

  // A nonzero cut stops after that many header bytes, with a valid serial and length.
  task automatic send_reply(input int unsigned cut);
    logic [7:0]  head[$];
    logic [15:0] ser;
    logic [15:0] len;
    logic [15:0] code;
    int unsigned pick;
    flush_to_start();
    ser = cur_serial;
    if (cur_4e && cut == 0 && $urandom_range(7) == 0) ser ^= 16'd1 << $urandom_range(15);
    pick = $urandom_range(99);
    if (cut != 0) len = 16'($urandom_range(40, 2));
    else if (pick < 10) len = 16'($urandom_range(1));
    else if (pick < 30) len = 16'd2;
    else if (pick < 75) len = 16'($urandom_range(12, 3));
    else if (pick < 98) len = 16'($urandom_range(40, 13));
    else len = 16'($urandom_range(400, 256));
    case ($urandom_range(3))
      0: code = prd_pkg::CODE_SUCCESS;
      1: begin
        case ($urandom_range(2))
          0: code = prd_pkg::CODE_DEV_B5;
          1: code = prd_pkg::CODE_DEV_200;
          default: code = prd_pkg::CODE_DEV_201;
        endcase
      end
      2: code = prd_pkg::PROTO_CODES[$urandom_range(prd_pkg::NumProtoCodes - 1)];
      default: code = 16'($urandom);
    endcase
    head.push_back(prd_pkg::SUBHEADER_B0);
    head.push_back(prd_pkg::SUBHEADER_B1);
    if (cur_4e) begin
      head.push_back(ser[7:0]);
      head.push_back(ser[15:8]);
    end
    repeat (5) head.push_back(8'($urandom));
    head.push_back(len[7:0]);
    head.push_back(len[15:8]);
    head.push_back(code[7:0]);
    head.push_back(code[15:8]);
    foreach (head[i]) if (cut == 0 || i < cut) send_byte(head[i]);
    if (cut == 0 && ser == cur_serial && len >= 16'd2)
      repeat (len - 16'd2) send_byte(8'($urandom));
  endtask

  task automatic send_noise();
    logic [7:0] b;
    case ($urandom_range(3))
      0: repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      1: begin
        flush_to_start();
        b = 8'($urandom);
        if (b == prd_pkg::SUBHEADER_B0) b = 8'hD1;
        send_byte(b);
      end
      2: begin
        flush_to_start();
        b = 8'($urandom_range(255, 1));
        send_byte(prd_pkg::SUBHEADER_B0);
        send_byte(b);
      end
      default: send_reply($urandom_range(cur_4e ? 12 : 10, 3));
    endcase
  endtask

  initial begin : result_side
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(kind_o, data_byte_o, reply_code_o, end_class_o, error_code_o, last_o);
      out_ready_i <= !take_gap();
    end
  end

  initial begin : stimulus
    logic [7:0]  opening[$];
    logic [15:0] mode;
    logic [15:0] ser;
    int unsigned ph;
    int unsigned pick;
    int unsigned cut_max;
    int unsigned waited;
    opening = '{8'hFF, 8'hD0, 8'h80, 8'hD0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                8'h03, 8'h00, 8'hB5, 8'hC0, 8'hFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening[i]) send_byte(opening[i]);
    settle();
    set_config(16'h0001, 16'hFFFF);
    send_byte(8'hD0);
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'hFF);

    for (ph = 0; ph < 8; ph++) begin
      // Leave a header half walked so that the frame type or serial can change under it.
      cut_max = cur_4e ? 12 : 10;
      send_reply($urandom_range(1) ? cut_max : $urandom_range(cut_max, 2));
      settle();
      mode = 16'($urandom);
      case (ph)
        0: begin
          mode[0] = 1'b0;
          ser     = 16'h0000;
        end
        1: begin
          mode[0] = 1'b1;
          ser     = 16'hFFFF;
        end
        2: begin
          mode[0] = 1'b1;
          ser     = 16'h0000;
        end
        3: begin
          mode[0] = 1'b0;
          ser     = 16'hFFFF;
        end
        default: ser = 16'($urandom);
      endcase
      set_config(mode, ser);
      quiet = (ph == 3);
      while (items_sent < 20 + (ph + 1) * 229) begin
        pick = $urandom_range(99);
        if (pick < 80) send_reply(0);
        else if (pick < 99) send_noise();
        else settle();
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
